[src/bsis_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the source-to-instruction compiler.
// No dependencies; every other file in src imports this package.
package bsis_pkg;

   localparam int MAX_PROGRAM = 65536;
   localparam int MAX_NESTING = 256;
   localparam int COUNT_W     = $clog2(MAX_PROGRAM + 1);
   localparam int LEVEL_W     = $clog2(MAX_NESTING + 1);
   localparam int RES_MAX     = 3;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LESS  = 8'h3C;
   localparam logic [7:0] CH_MORE  = 8'h3E;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef enum logic [2:0] {
      KIND_ADDVAL = 3'd0,
      KIND_ADDPTR = 3'd1,
      KIND_INPUT  = 3'd2,
      KIND_OUTPUT = 3'd3,
      KIND_BRZERO = 3'd4,
      KIND_BRNZ   = 3'd5,
      KIND_PATCH  = 3'd6,
      KIND_DONE   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK              = 3'd0,
      STAT_UNMATCHED_CLOSE = 3'd1,
      STAT_UNMATCHED_OPEN  = 3'd2,
      STAT_TOO_LONG        = 3'd3,
      STAT_TOO_DEEP        = 3'd4
   } stat_type;

   typedef enum logic [1:0] {
      RUN_NONE    = 2'd0,
      RUN_VALUE   = 2'd1,
      RUN_POINTER = 2'd2
   } run_type;

   typedef struct packed {
      logic [7:0] source_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        instr_index;
      logic [7:0]         value_amount;
      logic signed [15:0] pointer_amount;
      logic [15:0]        branch_target;
      logic [2:0]         status;
      logic               last_of_run;
   } rsp_type;

   // All result beats caused by one source beat.
   typedef struct packed {
      logic [1:0]            n_res;
      rsp_type [RES_MAX-1:0] res;
   } bnd_type;

   // Shift control shared by every stack cell.
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

endpackage

[src/bsis_stack_cell.sv]
`timescale 1ns / 1ps
// One cell of the shifting bracket stack: holds one open-branch index.
// Depends on bsis_pkg for the shift control struct.
module bsis_stack_cell
   import bsis_pkg::*;
(
   input  logic        clock,
   input  stk_ctl_type ctl,
   input  logic [15:0] from_above,
   input  logic [15:0] from_below,
   output logic [15:0] entry
);

   logic [15:0] entry_ff;
   logic [15:0] entry_in;

   // push: take neighbour nearer the top; pop: take neighbour below
   always_comb begin
      if (ctl.push) begin
         entry_in = from_above;
      end else if (ctl.pop) begin
         entry_in = from_below;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[src/bsis_compile.sv]
`timescale 1ns / 1ps
// Compiler state, run folding, bracket stack chain and result bundling.
// Depends on bsis_pkg and bsis_stack_cell.
module bsis_compile
   import bsis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req,
   output bnd_type bundle,
   output logic    bundle_push
);

   run_type            run_kind_ff,    run_kind_in;
   logic [7:0]         value_sum_ff,   value_sum_in;
   logic [15:0]        pointer_sum_ff, pointer_sum_in;
   logic [COUNT_W-1:0] instr_count_ff, instr_count_in;
   logic [LEVEL_W-1:0] stack_level_ff, stack_level_in;
   logic               halted_ff,      halted_in;
   stat_type           err_ff,         err_in;

   logic               is_end, is_val, is_ptr, is_out, is_in, is_open, is_close;
   logic               flush_need, flush_emit, flush_fail, room0, room1, op_live;
   logic               op_single, op_pair, do_push, do_pop;
   logic [COUNT_W-1:0] cnt_f;
   stat_type           fail_code, st_done;

   stk_ctl_type        stk_ctl;
   logic [15:0]        cells [MAX_NESTING];
   logic [15:0]        top_entry;

   rsp_type            fr, o0, o1;
   logic [1:0]         on, n;

   // ---------------- decode and decisions ----------------
   always_comb begin
      is_end   = req.end_of_text;
      is_val   = (req.source_char == CH_PLUS) || (req.source_char == CH_MINUS);
      is_ptr   = (req.source_char == CH_LESS) || (req.source_char == CH_MORE);
      is_out   = req.source_char == CH_DOT;
      is_in    = req.source_char == CH_COMMA;
      is_open  = req.source_char == CH_OPEN;
      is_close = req.source_char == CH_CLOSE;

      if (is_end) begin
         flush_need = !halted_ff && (run_kind_ff != RUN_NONE);
      end else if (halted_ff) begin
         flush_need = 1'b0;
      end else if (is_val) begin
         flush_need = run_kind_ff == RUN_POINTER;
      end else if (is_ptr) begin
         flush_need = run_kind_ff == RUN_VALUE;
      end else begin
         flush_need = run_kind_ff != RUN_NONE;
      end

      room0      = instr_count_ff < COUNT_W'(MAX_PROGRAM);
      flush_emit = flush_need && room0;
      flush_fail = flush_need && !room0;
      cnt_f      = instr_count_ff + COUNT_W'(flush_emit);
      room1      = cnt_f < COUNT_W'(MAX_PROGRAM);
      op_live    = !is_end && !halted_ff && !flush_fail && !is_val && !is_ptr;

      fail_code = STAT_OK;
      op_single = 1'b0;
      op_pair   = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      if (flush_fail) begin
         fail_code = STAT_TOO_LONG;
      end else if (op_live) begin
         if (is_out || is_in) begin
            if (room1) begin
               op_single = 1'b1;
            end else begin
               fail_code = STAT_TOO_LONG;
            end
         end else if (is_open) begin
            if (!room1) begin
               fail_code = STAT_TOO_LONG;
            end else if (stack_level_ff >= LEVEL_W'(MAX_NESTING)) begin
               fail_code = STAT_TOO_DEEP;
            end else begin
               do_push   = 1'b1;
               op_single = 1'b1;
            end
         end else if (is_close) begin
            if (stack_level_ff == '0) begin
               fail_code = STAT_UNMATCHED_CLOSE;
            end else if (!room1) begin
               fail_code = STAT_TOO_LONG;
            end else begin
               do_pop  = 1'b1;
               op_pair = 1'b1;
            end
         end
      end

      if (halted_ff) begin
         st_done = err_ff;
      end else if (flush_fail) begin
         st_done = STAT_TOO_LONG;
      end else if (stack_level_ff != '0) begin
         st_done = STAT_UNMATCHED_OPEN;
      end else begin
         st_done = STAT_OK;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      run_kind_in    = run_kind_ff;
      value_sum_in   = value_sum_ff;
      pointer_sum_in = pointer_sum_ff;
      instr_count_in = instr_count_ff;
      stack_level_in = stack_level_ff;
      halted_in      = halted_ff;
      err_in         = err_ff;
      if (take) begin
         if (is_end) begin
            run_kind_in    = RUN_NONE;
            value_sum_in   = '0;
            pointer_sum_in = '0;
            instr_count_in = '0;
            stack_level_in = '0;
            halted_in      = 1'b0;
            err_in         = STAT_OK;
         end else if (!halted_ff) begin
            instr_count_in = cnt_f;
            if (fail_code != STAT_OK) begin
               halted_in      = 1'b1;
               err_in         = fail_code;
               run_kind_in    = RUN_NONE;
               value_sum_in   = '0;
               pointer_sum_in = '0;
            end else if (is_val) begin
               run_kind_in    = RUN_VALUE;
               pointer_sum_in = '0;
               value_sum_in   = (req.source_char == CH_PLUS) ? value_sum_ff + 8'd1
                                                             : value_sum_ff - 8'd1;
            end else if (is_ptr) begin
               run_kind_in    = RUN_POINTER;
               value_sum_in   = '0;
               pointer_sum_in = (req.source_char == CH_MORE) ? pointer_sum_ff + 16'd1
                                                             : pointer_sum_ff - 16'd1;
            end else begin
               run_kind_in    = RUN_NONE;
               value_sum_in   = '0;
               pointer_sum_in = '0;
               instr_count_in = cnt_f + COUNT_W'(op_single || op_pair);
               if (do_push) begin
                  stack_level_in = stack_level_ff + LEVEL_W'(1);
               end else if (do_pop) begin
                  stack_level_in = stack_level_ff - LEVEL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff    <= RUN_NONE;
         value_sum_ff   <= '0;
         pointer_sum_ff <= '0;
         instr_count_ff <= '0;
         stack_level_ff <= '0;
         halted_ff      <= 1'b0;
         err_ff         <= STAT_OK;
      end else begin
         run_kind_ff    <= run_kind_in;
         value_sum_ff   <= value_sum_in;
         pointer_sum_ff <= pointer_sum_in;
         instr_count_ff <= instr_count_in;
         stack_level_ff <= stack_level_in;
         halted_ff      <= halted_in;
         err_ff         <= err_in;
      end
   end

   // ---------------- bracket stack: a chain of shifting cells ----------------
   assign stk_ctl.push = take && do_push;
   assign stk_ctl.pop  = take && do_pop;

   for (genvar i = 0; i < MAX_NESTING; i++) begin : g_cell
      logic [15:0] above, below;
      if (i == 0) begin : g_top
         assign above = cnt_f[15:0];
      end else begin : g_mid
         assign above = cells[i-1];
      end
      if (i == MAX_NESTING - 1) begin : g_bottom
         assign below = cells[i];
      end else begin : g_upper
         assign below = cells[i+1];
      end
      bsis_stack_cell u_cell (
         .clock      (clock),
         .ctl        (stk_ctl),
         .from_above (above),
         .from_below (below),
         .entry      (cells[i])
      );
   end

   assign top_entry = cells[0];

   // ---------------- result bundle ----------------
   always_comb begin
      fr = '0;
      fr.instr_index = instr_count_ff[15:0];
      if (run_kind_ff == RUN_VALUE) begin
         fr.kind         = KIND_ADDVAL;
         fr.value_amount = value_sum_ff;
      end else begin
         fr.kind           = KIND_ADDPTR;
         fr.pointer_amount = pointer_sum_ff;
      end

      o0 = '0;
      o1 = '0;
      on = 2'd0;
      if (is_end) begin
         o0.kind   = KIND_DONE;
         o0.status = st_done;
         on        = 2'd1;
      end else if (op_single) begin
         o0.instr_index = cnt_f[15:0];
         case (req.source_char)
            CH_DOT:   o0.kind = KIND_OUTPUT;
            CH_COMMA: o0.kind = KIND_INPUT;
            default:  o0.kind = KIND_BRZERO;
         endcase
         on = 2'd1;
      end else if (op_pair) begin
         o0.kind          = KIND_PATCH;
         o0.instr_index   = top_entry;
         o0.branch_target = cnt_f[15:0];
         o1.kind          = KIND_BRNZ;
         o1.instr_index   = cnt_f[15:0];
         o1.branch_target = top_entry;
         on               = 2'd2;
      end

      n = {1'b0, flush_emit} + on;
      bundle.n_res = n;
      bundle.res[0] = flush_emit ? fr : o0;
      bundle.res[1] = flush_emit ? o0 : o1;
      bundle.res[2] = o1;
      for (int i = 0; i < RES_MAX; i++) begin
         bundle.res[i].last_of_run = (2'(i) == n - 2'd1);
      end
   end

   assign bundle_push = take && (n != 2'd0);

endmodule

[src/bsis_out_queue.sv]
`timescale 1ns / 1ps
// Two-slot bundle queue that hands result beats out one per cycle while rsp_stall is low.
// Depends on bsis_pkg for the bundle and result types.
module bsis_out_queue
   import bsis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  bnd_type in_bundle,
   input  logic    in_push,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   bnd_type    head_ff,   head_in;
   bnd_type    wait_ff,   wait_in;
   logic       head_v_ff, head_v_in;
   logic       wait_v_ff, wait_v_in;
   logic [1:0] pos_ff,    pos_in;
   logic       fire, head_done, advance;

   always_comb begin
      fire      = head_v_ff && !rsp_stall;
      head_done = fire && (pos_ff == head_ff.n_res - 2'd1);
      advance   = !head_v_ff || head_done;

      head_in   = head_ff;
      wait_in   = wait_ff;
      head_v_in = head_v_ff;
      wait_v_in = wait_v_ff;
      pos_in    = pos_ff;
      if (advance) begin
         pos_in = 2'd0;
         if (wait_v_ff) begin
            head_in   = wait_ff;
            head_v_in = 1'b1;
            wait_v_in = 1'b0;
         end else begin
            head_in   = in_bundle;
            head_v_in = in_push;
         end
      end else begin
         if (fire) begin
            pos_in = pos_ff + 2'd1;
         end
         if (in_push) begin
            wait_in   = in_bundle;
            wait_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         wait_v_ff <= 1'b0;
         pos_ff    <= 2'd0;
      end else begin
         head_v_ff <= head_v_in;
         wait_v_ff <= wait_v_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      wait_ff <= wait_in;
   end

   assign full        = wait_v_ff;
   assign rsp_valid   = head_v_ff;
   assign rsp_payload = head_ff.res[pos_ff];

endmodule

[src/bf_source_to_instruction_stream_core.sv]
`timescale 1ns / 1ps
// Top level of the source-to-instruction compiler with run-length folding.
// Depends on bsis_pkg, bsis_compile (with its stack cells) and bsis_out_queue.
//
//   channel | dir | handshake           | beat
//   --------+-----+---------------------+-----------------------------------
//   req_    | in  | req_valid/req_stall | one source byte or end marker
//   rsp_    | out | rsp_valid/rsp_stall | one instruction, patch or done
//
// One source beat is taken per cycle while the waiting slot is free; its
// results (none to three) are worked out in that same cycle and hand on to a
// two-slot bundle queue. Result beats leave at one per cycle while rsp_stall
// is low, so multi-result beats can fill the waiting slot and raise req_stall.
// reset is synchronous: it clears run state, counters, stack level and queue
// flags; bracket stack contents are left as they are and never read unwritten.
// req_stall comes from a register only, never from rsp_stall.
module bf_source_to_instruction_stream_core
   import bsis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    take;
   logic    full;
   bnd_type bundle;
   logic    bundle_push;

   // accept a source beat whenever the waiting slot is free
   assign req_stall = full;
   assign take      = req_valid && !full;

   // fold runs, track brackets and build the result bundle
   bsis_compile u_compile (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req         (req_payload),
      .bundle      (bundle),
      .bundle_push (bundle_push)
   );

   // hold bundles and advance through their beats one by one
   bsis_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .in_bundle   (bundle),
      .in_push     (bundle_push),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // done always closes the results of its source beat
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_DONE) |-> rsp_payload.last_of_run)
      else $error("done beat not marked last");

   // a patch is always followed directly by its branch-if-nonzero
   a_patch_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_payload.kind == KIND_PATCH)
      |=> rsp_valid && (rsp_payload.kind == KIND_BRNZ)
          && (rsp_payload.branch_target == $past(rsp_payload.instr_index)))
      else $error("patch not followed by matching branch");

   // status is only carried by done
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != KIND_DONE) |-> (rsp_payload.status == STAT_OK))
      else $error("status on a non-done beat");

   // a bundle is never pushed while the waiting slot is occupied
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      full |-> !bundle_push)
      else $error("bundle pushed into a full queue");

endmodule

[sim/tb_bf_source_to_instruction_stream_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for bf_source_to_instruction_stream_core: an in-bench compiler model
// or a hand-written row gives each result beat, checked in order. Depends on bsis_pkg and the core RTL.
module tb_bf_source_to_instruction_stream_core;
   import bsis_pkg::*;

   // Directed row: either predicted by the compiler model, or written out by hand.
   typedef struct {
      logic [7:0] ch;
      logic       eot;
      bit         fixed;
      bit         has_want;
      rsp_type    want;
   } plan_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Compiler model state.
   run_type     cur_run  = RUN_NONE;
   logic [7:0]  val_acc  = '0;
   logic [15:0] ptr_acc  = '0;
   logic [16:0] icount   = '0;
   logic [15:0] open_stack [MAX_NESTING];
   logic [8:0]  depth    = '0;
   bit          stopped  = 1'b0;
   logic [2:0]  err_code = STAT_OK;

   rsp_type beat_instrs[$];   // results of the beat just compiled
   rsp_type instr_due[$];     // results still owed by the core, oldest first
   int      bad_beats  = 0;
   int      fed_beats  = 0;   // every source beat taken by the core
   bit      quiet      = 1'b0;
   int      stall_left = 0;

   bf_source_to_instruction_stream_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type mk(logic [2:0] k, int idx, int va, int pa, int tgt,
                                  logic [2:0] st);
      rsp_type r;
      r.kind           = k;
      r.instr_index    = idx[15:0];
      r.value_amount   = va[7:0];
      r.pointer_amount = pa[15:0];
      r.branch_target  = tgt[15:0];
      r.status         = st;
      r.last_of_run    = 1'b1;
      return r;
   endfunction

   // Append one result to the beat being compiled.
   function automatic void emit(rsp_type r);
      beat_instrs.insert(beat_instrs.size(), r);
   endfunction

   // Latch an error and drop whatever run was being folded.
   function automatic void halt_with(logic [2:0] code);
      stopped  = 1'b1;
      err_code = code;
      cur_run  = RUN_NONE;
      val_acc  = '0;
      ptr_acc  = '0;
   endfunction

   // True when another instruction fits; otherwise halt as too long.
   function automatic bit room();
      if (icount >= MAX_PROGRAM) begin
         halt_with(STAT_TOO_LONG);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Emit the open run, even one that folded to zero.
   function automatic void close_run();
      if (cur_run != RUN_NONE) begin
         if (!room()) return;
         if (cur_run == RUN_VALUE)
            emit(mk(KIND_ADDVAL, icount, val_acc, 0, 0, STAT_OK));
         else
            emit(mk(KIND_ADDPTR, icount, 0, ptr_acc, 0, STAT_OK));
         icount++;
      end
      cur_run = RUN_NONE;
      val_acc = '0;
      ptr_acc = '0;
   endfunction

   // Compile one source beat into beat_instrs.
   function automatic void compile_beat(logic [7:0] ch, logic eot);
      logic [2:0]  st;
      logic [15:0] open_at;
      beat_instrs.delete();
      if (eot) begin
         if (!stopped) close_run();
         if (stopped)        st = err_code;
         else if (depth != 0) st = STAT_UNMATCHED_OPEN;
         else                st = STAT_OK;
         emit(mk(KIND_DONE, 0, 0, 0, 0, st));
         // done puts the whole compiler back to its reset state
         cur_run  = RUN_NONE;
         val_acc  = '0;
         ptr_acc  = '0;
         icount   = '0;
         depth    = '0;
         stopped  = 1'b0;
         err_code = STAT_OK;
      end else if (!stopped) begin
         case (ch)
            CH_PLUS, CH_MINUS: begin
               if (cur_run == RUN_POINTER) close_run();
               if (!stopped) begin
                  cur_run = RUN_VALUE;
                  val_acc = (ch == CH_PLUS) ? val_acc + 8'd1 : val_acc - 8'd1;
               end
            end
            CH_LESS, CH_MORE: begin
               if (cur_run == RUN_VALUE) close_run();
               if (!stopped) begin
                  cur_run = RUN_POINTER;
                  ptr_acc = (ch == CH_MORE) ? ptr_acc + 16'd1 : ptr_acc - 16'd1;
               end
            end
            default: begin
               close_run();
               if (!stopped) begin
                  case (ch)
                     CH_DOT: if (room()) begin
                        emit(mk(KIND_OUTPUT, icount, 0, 0, 0, STAT_OK));
                        icount++;
                     end
                     CH_COMMA: if (room()) begin
                        emit(mk(KIND_INPUT, icount, 0, 0, 0, STAT_OK));
                        icount++;
                     end
                     CH_OPEN: if (room()) begin
                        if (depth >= MAX_NESTING) begin
                           halt_with(STAT_TOO_DEEP);
                        end else begin
                           open_stack[depth] = icount[15:0];
                           depth++;
                           emit(mk(KIND_BRZERO, icount, 0, 0, 0, STAT_OK));
                           icount++;
                        end
                     end
                     CH_CLOSE: begin
                        if (depth == 0) begin
                           halt_with(STAT_UNMATCHED_CLOSE);
                        end else if (room()) begin
                           depth--;
                           open_at = open_stack[depth];
                           emit(mk(KIND_PATCH, open_at, 0, 0, icount, STAT_OK));
                           emit(mk(KIND_BRNZ, icount, 0, 0, open_at, STAT_OK));
                           icount++;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         endcase
      end
      foreach (beat_instrs[i]) beat_instrs[i].last_of_run = (i == beat_instrs.size() - 1);
   endfunction

   // Offer one source beat, hold it until taken, then compile it in the model.
   task automatic feed_byte(input logic [7:0] ch, input logic eot, input bit predicted);
      req_type beat;
      beat.source_char = ch;
      beat.end_of_text = eot;
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fed_beats++;
      compile_beat(ch, eot);
      if (predicted) instr_due = {instr_due, beat_instrs};
   endtask

   // Hold the source side until the core has delivered everything owed.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (instr_due.size() != 0) @(posedge clock);
   endtask

   // One random program: mostly tidy bracket nesting, sometimes broken.
   task automatic random_program();
      int         len;
      int         open_n;
      int         pick;
      bit         tidy;
      logic [7:0] ch;
      tidy   = ($urandom_range(4) != 0);
      len    = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      open_n = 0;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            ch = $urandom_range(1) ? CH_PLUS : CH_MINUS;
         end else if (pick < 48) begin
            ch = $urandom_range(1) ? CH_MORE : CH_LESS;
         end else if (pick < 56) begin
            ch = CH_DOT;
         end else if (pick < 62) begin
            ch = CH_COMMA;
         end else if (pick < 74) begin
            if (tidy && open_n >= 6) begin
               ch = CH_DOT;
            end else begin
               ch = CH_OPEN;
               open_n++;
            end
         end else if (pick < 86) begin
            if (open_n > 0) begin
               ch = CH_CLOSE;
               open_n--;
            end else begin
               ch = tidy ? CH_COMMA : CH_CLOSE;
            end
         end else begin
            ch = 8'($urandom_range(255));   // comment noise, any byte at all
         end
         feed_byte(ch, 1'b0, 1'b1);
      end
      if (tidy) repeat (open_n) feed_byte(CH_CLOSE, 1'b0, 1'b1);
      feed_byte(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   // Result side: stall in random bursts, none once quiet.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Compare every delivered result beat with the oldest one owed.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (instr_due.size() == 0) begin
            if (bad_beats < 10)
               $display("unexpected result beat: kind %0d idx %0d", rsp_payload.kind,
                        rsp_payload.instr_index);
            bad_beats++;
         end else begin
            exp_r = instr_due.pop_front();
            if (rsp_payload.kind           !== exp_r.kind           ||
                rsp_payload.instr_index    !== exp_r.instr_index    ||
                rsp_payload.value_amount   !== exp_r.value_amount   ||
                rsp_payload.pointer_amount !== exp_r.pointer_amount ||
                rsp_payload.branch_target  !== exp_r.branch_target  ||
                rsp_payload.status         !== exp_r.status         ||
                rsp_payload.last_of_run    !== exp_r.last_of_run) begin
               if (bad_beats < 10) begin
                  $display({"mismatch: expected kind %0d idx %0d val %h ptr %h",
                            " tgt %0d st %0d last %b"},
                           exp_r.kind, exp_r.instr_index, exp_r.value_amount,
                           exp_r.pointer_amount, exp_r.branch_target, exp_r.status,
                           exp_r.last_of_run);
                  $display({"          actual   kind %0d idx %0d val %h ptr %h",
                            " tgt %0d st %0d last %b"},
                           rsp_payload.kind, rsp_payload.instr_index,
                           rsp_payload.value_amount, rsp_payload.pointer_amount,
                           rsp_payload.branch_target, rsp_payload.status,
                           rsp_payload.last_of_run);
               end
               bad_beats++;
            end
         end
      end
   end

   initial begin
      plan_row_type plan [24];

      // empty program, then an early close that halts and swallows input
      plan[0]  = '{CH_CLOSE, 1'b1, 1'b1, 1'b1, mk(KIND_DONE, 0, 0, 0, 0, STAT_OK)};
      plan[1]  = '{CH_CLOSE, 1'b0, 1'b1, 1'b0, '0};
      plan[2]  = '{CH_PLUS,  1'b0, 1'b1, 1'b0, '0};
      plan[3]  = '{8'hFF,    1'b1, 1'b1, 1'b1,
                   mk(KIND_DONE, 0, 0, 0, 0, STAT_UNMATCHED_CLOSE)};
      // a value run that folds to zero is still emitted
      plan[4]  = '{CH_MINUS, 1'b0, 1'b1, 1'b0, '0};
      plan[5]  = '{CH_PLUS,  1'b0, 1'b1, 1'b0, '0};
      plan[6]  = '{CH_MORE,  1'b0, 1'b1, 1'b1, mk(KIND_ADDVAL, 0, 0, 0, 0, STAT_OK)};
      plan[7]  = '{CH_LESS,  1'b0, 1'b0, 1'b0, '0};
      plan[8]  = '{CH_LESS,  1'b0, 1'b0, 1'b0, '0};
      // comment bytes end a run: pointer sum of minus one, then byte sum 0xFF
      plan[9]  = '{8'h00,    1'b0, 1'b1, 1'b1, mk(KIND_ADDPTR, 1, 0, 'hFFFF, 0, STAT_OK)};
      plan[10] = '{CH_MINUS, 1'b0, 1'b0, 1'b0, '0};
      plan[11] = '{8'hFF,    1'b0, 1'b1, 1'b1, mk(KIND_ADDVAL, 2, 'hFF, 0, 0, STAT_OK)};
      plan[12] = '{CH_COMMA, 1'b0, 1'b0, 1'b0, '0};
      plan[13] = '{CH_DOT,   1'b0, 1'b0, 1'b0, '0};
      plan[14] = '{CH_OPEN,  1'b0, 1'b0, 1'b0, '0};
      plan[15] = '{CH_PLUS,  1'b0, 1'b0, 1'b0, '0};
      // close after a run: addval, patch and branch back, three beats
      plan[16] = '{CH_CLOSE, 1'b0, 1'b0, 1'b0, '0};
      plan[17] = '{CH_OPEN,  1'b0, 1'b0, 1'b0, '0};
      plan[18] = '{8'h00,    1'b1, 1'b1, 1'b1,
                   mk(KIND_DONE, 0, 0, 0, 0, STAT_UNMATCHED_OPEN)};
      // end marker flushing an open pointer run
      plan[19] = '{CH_MORE,  1'b0, 1'b0, 1'b0, '0};
      plan[20] = '{CH_DOT,   1'b1, 1'b0, 1'b0, '0};
      plan[21] = '{CH_OPEN,  1'b0, 1'b0, 1'b0, '0};
      plan[22] = '{CH_CLOSE, 1'b0, 1'b0, 1'b0, '0};
      plan[23] = '{8'hAA,    1'b1, 1'b1, 1'b1, mk(KIND_DONE, 0, 0, 0, 0, STAT_OK)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         feed_byte(plan[i].ch, plan[i].eot, !plan[i].fixed);
         if (plan[i].fixed && plan[i].has_want)
            instr_due.insert(instr_due.size(), plan[i].want);
      end
      drain_results();

      // Nest to the limit, close one, reopen, then one level too many.
      repeat (MAX_NESTING) feed_byte(CH_OPEN, 1'b0, 1'b1);
      feed_byte(CH_DOT,   1'b0, 1'b1);
      feed_byte(CH_CLOSE, 1'b0, 1'b1);
      feed_byte(CH_OPEN,  1'b0, 1'b1);
      feed_byte(CH_OPEN,  1'b0, 1'b1);
      feed_byte(CH_CLOSE, 1'b0, 1'b1);
      feed_byte(8'h00,    1'b1, 1'b1);

      // Random programs; the final stretch runs with no idling on either side.
      while (fed_beats < 460) begin
         if (fed_beats >= 400) quiet = 1'b1;
         random_program();
         if (!quiet && $urandom_range(7) == 0) drain_results();
      end
      req_valid <= 1'b0;

      while (instr_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (bad_beats == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #400_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[bf_source_to_instruction_stream_core.f]
src/bsis_pkg.sv
src/bsis_stack_cell.sv
src/bsis_compile.sv
src/bsis_out_queue.sv
src/bf_source_to_instruction_stream_core.sv
sim/tb_bf_source_to_instruction_stream_core.sv
